### rtl/i2c_master_transfer_sequencer_defines.svh
// Assertion helpers used by the top-level RTL module.
`ifndef I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH
`define I2C_MASTER_TRANSFER_SEQUENCER_DEFINES_SVH

// Property holds at every clock edge outside reset.
`define I2CMTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define I2CMTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/i2cmts_pkg.sv
package i2cmts_pkg;

    localparam int DEF_BUF_DEPTH = 32;

    // request kinds
    localparam logic [2:0] REQ_LOAD     = 3'd0;
    localparam logic [2:0] REQ_BEGIN    = 3'd1;
    localparam logic [2:0] REQ_TX_READY = 3'd2;
    localparam logic [2:0] REQ_RX_BYTE  = 3'd3;
    localparam logic [2:0] REQ_NACK     = 3'd4;

    // bus actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_SEND    = 3'd1;
    localparam logic [2:0] ACT_RESTART = 3'd2;
    localparam logic [2:0] ACT_STOP    = 3'd3;
    localparam logic [2:0] ACT_STORE   = 3'd4;

    // config register indexes
    localparam logic [1:0] CFG_MASTER_EN = 2'd0;
    localparam logic [1:0] CFG_TX_RETRY  = 2'd1;
    localparam logic [1:0] CFG_RX_RETRY  = 2'd2;

    localparam logic [3:0] RETRY_RESET = 4'd3;

    typedef struct packed {
        logic [2:0] action;
        logic [7:0] byte_val;   // received byte (store) or 0
        logic [4:0] byte_index;
        logic       busy;
        logic       use_mem;    // byte comes from the tx buffer read
    } t_step;

endpackage

### rtl/i2c_master_transfer_sequencer.sv
// I2C master transfer sequencer, byte level, with NACK retry.
// Slave channel (i_s_*): one beat per request. tuser carries the request
// kind (load tx byte, begin, tx ready, rx byte, nack); tdata the operands.
// Master channel (o_m_*): exactly one result beat per request beat, in order:
// bus action in tuser, byte, byte index and busy flag in tdata.
// Config channel (i_cfg_*): register writes, always ready, to be issued only
// while the block is idle; index 0 master enable, 1 tx retry limit, 2 rx retry limit.
// Throughput: one request per cycle sustained while the receiver takes each
// result beat. A request passes through the read stage, which covers the tx
// buffer's registered read, and then the output register, which drives the
// result beat.
// The tx buffer is a BUF_DEPTH x 8 single-port-write RAM; load and send
// use separate cycles, so a byte loaded is visible to the next send.
// Transfer state (direction, length, count, tries) updates in the accept
// cycle, so back-to-back events see each other's effects.
// Reset (synchronous, active low) clears the transfer state, sets master
// enable and both retry limits to 3; buffer contents stay undefined.
// Receiver stall: the output register holds its beat; one more request can
// still enter the read stage, after which o_s_tready drops until space frees.
module i2c_master_transfer_sequencer #(
    parameter int BUF_DEPTH = i2cmts_pkg::DEF_BUF_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // direction[0], transfer_length[6:1],
                                     // byte_value[14:7], load_index[19:15], zero
    input  logic [2:0]  i_s_tuser,   // req_type[2:0]
    // result channel
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // byte_out[7:0], byte_index[12:8],
                                     // busy_res[13], zero
    output logic [2:0]  o_m_tuser,   // action[2:0]
    // config channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [3:0]  i_cfg_data
);
    import i2cmts_pkg::*;
    `include "i2c_master_transfer_sequencer_defines.svh"

    localparam int AW = $clog2(BUF_DEPTH);

    logic          accept;
    t_step         step;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic [7:0]    mem_q;

    // read stage: holds step while the buffer read completes
    logic          r_s1_valid;
    t_step         r_s1_step;
    logic          s1_adv;

    // output register
    logic          r_out_valid;
    logic [2:0]    r_out_act;
    logic [7:0]    r_out_byte;
    logic [4:0]    r_out_idx;
    logic          r_out_busy;

    assign s1_adv     = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_s1_valid || s1_adv;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    i2cmts_ctrl #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_ctrl (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (accept),
        .i_req_type        (i_s_tuser),
        .i_direction       (i_s_tdata[0]),
        .i_transfer_length (i_s_tdata[6:1]),
        .i_byte_value      (i_s_tdata[14:7]),
        .i_load_index      (i_s_tdata[19:15]),
        .i_cfg_we          (i_cfg_valid),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .o_step            (step),
        .o_wr_en           (wr_en),
        .o_wr_addr         (wr_addr),
        .o_rd_en           (rd_en),
        .o_rd_addr         (rd_addr)
    );

    // read data is held while the stage stalls (no accept, no new read)
    i2cmts_tx_ram #(
        .BUF_DEPTH (BUF_DEPTH),
        .AW        (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_s_tdata[14:7]),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (mem_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_step <= step;
        end
        if (s1_adv && r_s1_valid) begin
            r_out_act  <= r_s1_step.action;
            r_out_byte <= r_s1_step.use_mem ? mem_q : r_s1_step.byte_val;
            r_out_idx  <= r_s1_step.byte_index;
            r_out_busy <= r_s1_step.busy;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_act;
    assign o_m_tdata  = {2'b00, r_out_busy, r_out_idx, r_out_byte};

    `I2CMTS_ASSERT(a_ready_only_when_full, i_clk, i_rst_n,
        !o_s_tready |-> (r_s1_valid && r_out_valid && !i_m_tready), "ready low with room")
    `I2CMTS_ASSERT_NEXT(a_s1_kept_on_stall, i_clk, i_rst_n,
        (r_s1_valid && r_out_valid && !i_m_tready), r_s1_valid, "read stage beat lost")
    `I2CMTS_ASSERT(a_stop_clears_busy, i_clk, i_rst_n,
        (o_m_tvalid && o_m_tuser == ACT_STOP) |-> !o_m_tdata[13], "stop with busy set")
    `I2CMTS_ASSERT(a_send_while_busy, i_clk, i_rst_n,
        (o_m_tvalid && (o_m_tuser == ACT_SEND || o_m_tuser == ACT_STORE)) |-> o_m_tdata[13],
        "byte moved while not busy")

endmodule

### rtl/i2cmts_tx_ram.sv
module i2cmts_tx_ram #(
    parameter int BUF_DEPTH = 32,
    parameter int AW        = 5
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [BUF_DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_q <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_q;

endmodule

### rtl/i2cmts_ctrl.sv
module i2cmts_ctrl #(
    parameter int BUF_DEPTH = 32,
    parameter int AW        = 5
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [2:0]          i_req_type,
    input  logic                i_direction,
    input  logic [5:0]          i_transfer_length,
    input  logic [7:0]          i_byte_value,
    input  logic [4:0]          i_load_index,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [3:0]          i_cfg_data,
    output i2cmts_pkg::t_step   o_step,
    output logic                o_wr_en,
    output logic [AW-1:0]       o_wr_addr,
    output logic                o_rd_en,
    output logic [AW-1:0]       o_rd_addr
);
    import i2cmts_pkg::*;

    localparam int XW = (AW > 6) ? AW : 6;
    localparam logic [XW:0] DEPTH_C = (XW+1)'(BUF_DEPTH);

    logic       r_master_en;
    logic [3:0] r_tx_limit;
    logic [3:0] r_rx_limit;
    logic       r_in_prog, n_in_prog;
    logic       r_dir_tx,  n_dir_tx;
    logic [5:0] r_len,     n_len;
    logic [5:0] r_done,    n_done;
    logic [3:0] r_tries,   n_tries;

    logic [XW:0] lidx_x;
    logic [XW:0] done_x;
    logic [XW:0] tlen_x;
    logic        active;
    logic [3:0]  limit;
    t_step       step;
    logic        wr_ok;

    assign lidx_x = (XW+1)'(i_load_index);
    assign done_x = (XW+1)'(r_done);
    assign tlen_x = (XW+1)'(i_transfer_length);
    assign active = r_in_prog && r_master_en;
    assign limit  = r_dir_tx ? r_tx_limit : r_rx_limit;

    always_comb begin
        n_in_prog       = r_in_prog;
        n_dir_tx        = r_dir_tx;
        n_len           = r_len;
        n_done          = r_done;
        n_tries         = r_tries;
        wr_ok           = 1'b0;
        step.action     = ACT_NONE;
        step.byte_val   = 8'd0;
        step.byte_index = 5'd0;
        step.use_mem    = 1'b0;
        case (i_req_type)
            REQ_LOAD: begin
                wr_ok = (lidx_x < DEPTH_C);
            end
            REQ_BEGIN: begin
                n_dir_tx  = i_direction;
                n_len     = (tlen_x > DEPTH_C) ? 6'(BUF_DEPTH) : i_transfer_length;
                n_done    = 6'd0;
                n_tries   = 4'd0;
                n_in_prog = 1'b1;
            end
            REQ_TX_READY: begin
                if (active && r_dir_tx) begin
                    if (r_done < r_len && done_x < DEPTH_C) begin
                        n_done          = r_done + 6'd1;
                        step.action     = ACT_SEND;
                        step.byte_index = r_done[4:0];
                        step.use_mem    = 1'b1;
                    end else begin
                        n_in_prog   = 1'b0;
                        step.action = ACT_STOP;
                    end
                end
            end
            REQ_RX_BYTE: begin
                if (active && !r_dir_tx) begin
                    if (r_done < r_len) begin
                        n_done          = r_done + 6'd1;
                        step.action     = ACT_STORE;
                        step.byte_val   = i_byte_value;
                        step.byte_index = r_done[4:0];
                    end else begin
                        n_in_prog   = 1'b0;
                        step.action = ACT_STOP;
                    end
                end
            end
            REQ_NACK: begin
                if (active) begin
                    if (r_tries < limit) begin
                        n_tries = r_tries + 4'd1;
                        if (r_dir_tx && r_done != 6'd0) begin
                            n_done = r_done - 6'd1;
                        end
                        step.action     = ACT_RESTART;
                        step.byte_index = n_done[4:0];
                    end else begin
                        n_in_prog   = 1'b0;
                        step.action = ACT_STOP;
                    end
                end
            end
            default: begin
            end
        endcase
        step.busy = n_in_prog;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_prog   <= 1'b0;
            r_dir_tx    <= 1'b0;
            r_len       <= 6'd0;
            r_done      <= 6'd0;
            r_tries     <= 4'd0;
            r_master_en <= 1'b1;
            r_tx_limit  <= RETRY_RESET;
            r_rx_limit  <= RETRY_RESET;
        end else begin
            if (i_accept) begin
                r_in_prog <= n_in_prog;
                r_dir_tx  <= n_dir_tx;
                r_len     <= n_len;
                r_done    <= n_done;
                r_tries   <= n_tries;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MASTER_EN: r_master_en <= i_cfg_data[0];
                    CFG_TX_RETRY:  r_tx_limit  <= i_cfg_data;
                    CFG_RX_RETRY:  r_rx_limit  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_step    = step;
    assign o_wr_en   = i_accept && wr_ok;
    assign o_wr_addr = lidx_x[AW-1:0];
    assign o_rd_en   = i_accept && step.use_mem;
    assign o_rd_addr = done_x[AW-1:0];

endmodule
